/* rtl/core/keyboard_scancode_decoder_core_assert.svh */
// Assertion macros for the keyboard scancode decoder core.
// Expects clk and arst_n in the scope of each use.
`ifndef KEYBOARD_SCANCODE_DECODER_CORE_ASSERT_SVH
`define KEYBOARD_SCANCODE_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define KSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ksd assertion failed");

// next-cycle implication
`define KSD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ksd assertion failed");

`endif

/* rtl/core/ksd_pkg.sv */
// Shared types and constants for the keyboard scancode decoder core.
// No dependencies.
package ksd_pkg;

	localparam int KEY_W    = 16;
	localparam int CODE_W   = 7;
	localparam int KM_ROWS  = 128;
	localparam int KM_TBLS  = 4;
	localparam int CFG_NUM  = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_OUT_W = 4;

	localparam logic [7:0] ESCAPE_BYTE = 8'hE0;

	localparam logic [KEY_W-1:0] CH_LOWER_A = 16'h0061;
	localparam logic [KEY_W-1:0] CH_LOWER_Z = 16'h007A;
	localparam logic [KEY_W-1:0] CH_UPPER_A = 16'h0041;
	localparam logic [KEY_W-1:0] CH_UPPER_Z = 16'h005A;
	localparam logic [KEY_W-1:0] CASE_DELTA = 16'h0020;

	typedef enum logic [1:0] {
		OP_SCAN   = 2'd0,
		OP_POP    = 2'd1,
		OP_KEYMAP = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TBL_PLAIN = 2'd0,
		TBL_SHIFT = 2'd1,
		TBL_ALTGR = 2'd2,
		TBL_ESC   = 2'd3
	} tbl_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LSHIFT   = 3'd0,
		CFG_RSHIFT   = 3'd1,
		CFG_LCONTROL = 3'd2,
		CFG_RCONTROL = 3'd3,
		CFG_LALT     = 3'd4,
		CFG_RALT     = 3'd5,
		CFG_CAPSLOCK = 3'd6,
		CFG_NONE     = 3'd7
	} cfg_idx_t;

	localparam logic [KEY_W-1:0] CFG_RESET_BASE = 16'd256;

	typedef struct packed {
		logic [4:0]        pad;
		logic [KEY_W-1:0]  table_value;
		logic [CODE_W-1:0] table_index;
		logic [1:0]        table_select;
		logic [7:0]        scan_byte;
		logic [1:0]        op;
	} in_item_t;

	typedef struct packed {
		logic [6:0]           pad;
		logic [CNT_OUT_W-1:0] buffered_count;
		logic                 caps_on;
		logic                 unknown_code;
		logic                 key_dropped;
		logic                 key_pushed;
		logic [KEY_W-1:0]     popped_key;
		logic                 pop_valid;
	} out_item_t;

	typedef struct packed {
		logic              en;
		logic [1:0]        sel;
		logic [CODE_W-1:0] idx;
		logic [KEY_W-1:0]  val;
	} km_wr_t;

	typedef logic [KM_TBLS-1:0][KEY_W-1:0] km_row_t;

	function automatic logic [KEY_W-1:0] flip_case(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] r;
		r = k;
		if (k inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
			r = k - CASE_DELTA;
		end else if (k inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
			r = k + CASE_DELTA;
		end
		return r;
	endfunction

endpackage

/* rtl/core/ksd_keymap.sv */
// Keymap storage: 128 rows, each holding the entry of all four tables.
// One registered row read, one lane write per cycle. Depends on ksd_pkg.
module ksd_keymap
	import ksd_pkg::*;
(
	input  logic              clk,
	input  logic              rd_en,
	input  logic [CODE_W-1:0] rd_idx,
	input  km_wr_t            wr,
	output km_row_t           rd_row
);

	km_row_t mem [KM_ROWS];
	km_row_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx][wr.sel] <= wr.val;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_row = rd_data_q;

endmodule

/* rtl/core/keyboard_scancode_decoder_core.sv */
// Keyboard scancode decoder (set 1): a keymap lookup, modifier tracking and a key ring.
// An item is taken every cycle; its result passes the keymap read register and then the
// output register: the transfer edge reads the keymap row (all four tables at once), and
// once the output register is free an edge picks the table from the current escape, shift
// and AltGr flags, updates state and loads the output register. Input stalls only while
// a result waits in the output register, another item waits behind it and the receiver
// holds off. The ring head is kept in a registered read of the ring memory, forwarded
// when a push lands on the head slot. Keymap and ring contents are not cleared: load
// every keymap entry that can be looked up before use.
// Depends on ksd_pkg, ksd_keymap and keyboard_scancode_decoder_core_assert.svh.
`include "keyboard_scancode_decoder_core_assert.svh"

module keyboard_scancode_decoder_core
	import ksd_pkg::*;
#(
	parameter int BUFFER_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// op, scan_byte, table_select, table_index, table_value, zero pad
	input  logic [39:0]          s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// pop_valid, popped_key, key_pushed, key_dropped, unknown_code, caps_on,
	// buffered_count, zero pad
	output logic [31:0]          m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data
);

	localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W = (PTR_W + 1 > 5) ? PTR_W + 1 : 5;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

	in_item_t  in_item;
	out_item_t out_q;
	out_item_t out_d;
	logic      out_valid_q;

	logic      s_fire;
	logic      adv;
	logic      valid_s1;
	logic [1:0] op_s1;
	logic [7:0] byte_s1;
	km_row_t   row_s1;
	km_wr_t    km_wr;

	logic [KEY_W-1:0] cfg_q [CFG_NUM];

	logic esc_q, shift_q, caps_q, lctrl_q, rctrl_q, lalt_q, altgr_q;
	logic esc_d, shift_d, caps_d, lctrl_d, rctrl_d, lalt_d, altgr_d;

	logic [KEY_W-1:0] ring_mem [BUFFER_DEPTH];
	logic [KEY_W-1:0] head_q;
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_next, rd_next, wr_inc, rd_inc;
	logic             push, pop, drop, unknown;
	logic [KEY_W-1:0] key, push_key;
	logic             down;
	tbl_t             tbl;
	logic [CNT_W-1:0] cnt;

	assign in_item   = in_item_t'(s_tdata);
	assign cfg_ready = 1'b1;
	assign s_tready  = !valid_s1 || !out_valid_q || m_tready;
	assign s_fire    = s_tvalid && s_tready;
	assign adv       = valid_s1 && (!out_valid_q || m_tready);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++) begin
				cfg_q[i] <= CFG_RESET_BASE + KEY_W'(i);
			end
		end else if (cfg_valid && cfg_index != CFG_NONE) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// issue the row read and keymap writes at the input transfer
	always_comb begin
		km_wr.en  = s_fire && (in_item.op == OP_KEYMAP);
		km_wr.sel = in_item.table_select;
		km_wr.idx = in_item.table_index;
		km_wr.val = in_item.table_value;
	end

	ksd_keymap u_keymap (
		.clk    (clk),
		.rd_en  (s_fire),
		.rd_idx (in_item.scan_byte[CODE_W-1:0]),
		.wr     (km_wr),
		.rd_row (row_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1   <= in_item.op;
			byte_s1 <= in_item.scan_byte;
		end
	end

	assign wr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;

	always_comb begin
		esc_d   = esc_q;
		shift_d = shift_q;
		caps_d  = caps_q;
		lctrl_d = lctrl_q;
		rctrl_d = rctrl_q;
		lalt_d  = lalt_q;
		altgr_d = altgr_q;
		push    = 1'b0;
		drop    = 1'b0;
		unknown = 1'b0;
		pop     = 1'b0;
		down    = !byte_s1[7];
		push_key = '0;
		if (esc_q) begin
			tbl = TBL_ESC;
		end else if (shift_q) begin
			tbl = TBL_SHIFT;
		end else if (altgr_q) begin
			tbl = TBL_ALTGR;
		end else begin
			tbl = TBL_PLAIN;
		end
		key = row_s1[tbl];
		case (op_t'(op_s1))
			OP_SCAN: begin
				if (byte_s1 == ESCAPE_BYTE) begin
					esc_d = 1'b1;
				end else begin
					esc_d = 1'b0;
					if (key == cfg_q[CFG_LSHIFT] || key == cfg_q[CFG_RSHIFT]) begin
						shift_d = down;
					end else if (key == cfg_q[CFG_LCONTROL]) begin
						lctrl_d = down;
					end else if (key == cfg_q[CFG_RCONTROL]) begin
						rctrl_d = down;
					end else if (key == cfg_q[CFG_LALT]) begin
						lalt_d = down;
					end else if (key == cfg_q[CFG_RALT]) begin
						altgr_d = down;
					end else if (key == cfg_q[CFG_CAPSLOCK]) begin
						caps_d = caps_q ^ down;
					end else if (down) begin
						if (key == '0) begin
							unknown = 1'b1;
						end else if (wr_inc == rd_ptr_q) begin
							drop = 1'b1;
						end else begin
							push = 1'b1;
						end
					end
				end
				push_key = caps_q ? flip_case(key) : key;
			end
			OP_POP: begin
				pop = (wr_ptr_q != rd_ptr_q);
			end
			default: begin
			end
		endcase
	end

	assign wr_next = (adv && push) ? wr_inc : wr_ptr_q;
	assign rd_next = (adv && pop) ? rd_inc : rd_ptr_q;

	always_comb begin
		if (wr_next >= rd_next) begin
			cnt = CNT_W'(wr_next) - CNT_W'(rd_next);
		end else begin
			cnt = CNT_W'(BUFFER_DEPTH) - (CNT_W'(rd_next) - CNT_W'(wr_next));
		end
		out_d.pad            = '0;
		out_d.pop_valid      = pop;
		out_d.popped_key     = pop ? head_q : '0;
		out_d.key_pushed     = push;
		out_d.key_dropped    = drop;
		out_d.unknown_code   = unknown;
		out_d.caps_on        = caps_d;
		out_d.buffered_count = (cnt > CNT_W'(15)) ? CNT_OUT_W'(15) : cnt[CNT_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q       <= 1'b0;
			shift_q     <= 1'b0;
			caps_q      <= 1'b0;
			lctrl_q     <= 1'b0;
			rctrl_q     <= 1'b0;
			lalt_q      <= 1'b0;
			altgr_q     <= 1'b0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				esc_q   <= esc_d;
				shift_q <= shift_d;
				caps_q  <= caps_d;
				lctrl_q <= lctrl_d;
				rctrl_q <= rctrl_d;
				lalt_q  <= lalt_d;
				altgr_q <= altgr_d;
			end
			wr_ptr_q <= wr_next;
			rd_ptr_q <= rd_next;
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= out_d;
		end
	end

	// ring memory; forward a push that lands on the new head slot
	always_ff @(posedge clk) begin
		if (adv && push) begin
			ring_mem[wr_ptr_q] <= push_key;
		end
		if (adv && push && wr_ptr_q == rd_next) begin
			head_q <= push_key;
		end else begin
			head_q <= ring_mem[rd_next];
		end
	end

	`KSD_ASSERT_IMP(a_push_not_full, adv && push, wr_inc != rd_ptr_q)
	`KSD_ASSERT_IMP(a_pop_not_empty, adv && pop, wr_ptr_q != rd_ptr_q)
	`KSD_ASSERT_IMP(a_one_outcome, adv, $onehot0({push, drop, unknown, pop}))
	`KSD_ASSERT_IMP(a_stall_cause, !s_tready, valid_s1 && out_valid_q && !m_tready)
	`KSD_ASSERT_NXT(a_result_follows, adv, m_tvalid)

endmodule

/* tb/sv/keyboard_scancode_decoder_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for keyboard_scancode_decoder_core: watches the input, result and register
// channels, predicts each result from its own copy of the decoder state and compares.
// Depends on ksd_pkg.
module keyboard_scancode_decoder_checker
	import ksd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [39:0]          s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [31:0]          m_tdata,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   results_outstanding
);

	logic [KEY_W-1:0] key_codes [CFG_NUM];
	logic [KEY_W-1:0] keymap [KM_TBLS*KM_ROWS];
	logic [KEY_W-1:0] key_ring [16];
	logic [3:0]       wr_ptr;
	logic [3:0]       rd_ptr;
	logic             esc_armed;
	logic             shift_on;
	logic             caps_lock;
	logic             lctrl_on;
	logic             rctrl_on;
	logic             lalt_on;
	logic             altgr_on;
	out_item_t        decode_results_q[$];
	out_item_t        got;
	out_item_t        want;
	out_item_t        pred;

	function automatic logic [KEY_W-1:0] swap_case(input logic [KEY_W-1:0] k);
		if (k >= CH_LOWER_A && k <= CH_LOWER_Z) begin
			return k - 16'h0020;
		end
		if (k >= CH_UPPER_A && k <= CH_UPPER_Z) begin
			return k + 16'h0020;
		end
		return k;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns  mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int unsigned seen, input int unsigned exp);
		if (seen != exp) begin
			report_mismatch($sformatf("%s got %0h want %0h", name, seen, exp));
		end
	endtask

	task automatic decode_item(input in_item_t it, output out_item_t res);
		logic             press;
		tbl_t             tsel;
		logic [KEY_W-1:0] key;
		logic [3:0]       next_wr;
		res = '0;
		case (op_t'(it.op))
			OP_SCAN: begin
				if (it.scan_byte == ESCAPE_BYTE) begin
					esc_armed = 1'b1;
				end else begin
					press = !it.scan_byte[7];
					if (esc_armed) begin
						tsel = TBL_ESC;
					end else if (shift_on) begin
						tsel = TBL_SHIFT;
					end else if (altgr_on) begin
						tsel = TBL_ALTGR;
					end else begin
						tsel = TBL_PLAIN;
					end
					key = keymap[{tsel, it.scan_byte[6:0]}];
					if (key == key_codes[CFG_LSHIFT] || key == key_codes[CFG_RSHIFT]) begin
						shift_on = press;
					end else if (key == key_codes[CFG_LCONTROL]) begin
						lctrl_on = press;
					end else if (key == key_codes[CFG_RCONTROL]) begin
						rctrl_on = press;
					end else if (key == key_codes[CFG_LALT]) begin
						lalt_on = press;
					end else if (key == key_codes[CFG_RALT]) begin
						altgr_on = press;
					end else if (key == key_codes[CFG_CAPSLOCK]) begin
						if (press) begin
							caps_lock = !caps_lock;
						end
					end else if (press) begin
						if (key != '0) begin
							if (caps_lock) begin
								key = swap_case(key);
							end
							next_wr = wr_ptr + 4'd1;
							if (next_wr != rd_ptr) begin
								key_ring[wr_ptr] = key;
								wr_ptr = next_wr;
								res.key_pushed = 1'b1;
							end else begin
								res.key_dropped = 1'b1;
							end
						end else begin
							res.unknown_code = 1'b1;
						end
					end
					esc_armed = 1'b0;
				end
			end
			OP_POP: begin
				if (wr_ptr != rd_ptr) begin
					res.pop_valid = 1'b1;
					res.popped_key = key_ring[rd_ptr];
					rd_ptr = rd_ptr + 4'd1;
				end
			end
			OP_KEYMAP: begin
				keymap[{it.table_select, it.table_index}] = it.table_value;
			end
			default: begin
			end
		endcase
		res.caps_on = caps_lock;
		res.buffered_count = wr_ptr - rd_ptr;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++) begin
				key_codes[i] = CFG_RESET_BASE + KEY_W'(i);
			end
			for (int i = 0; i < KM_TBLS*KM_ROWS; i++) begin
				keymap[i] = '0;
			end
			for (int i = 0; i < 16; i++) begin
				key_ring[i] = '0;
			end
			wr_ptr = '0;
			rd_ptr = '0;
			esc_armed = 1'b0;
			shift_on = 1'b0;
			caps_lock = 1'b0;
			lctrl_on = 1'b0;
			rctrl_on = 1'b0;
			lalt_on = 1'b0;
			altgr_on = 1'b0;
			decode_results_q.delete();
			fail_count = 0;
			results_outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (decode_results_q.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing expected", m_tdata));
				end else begin
					want = decode_results_q.pop_front();
					check_field("pop_valid", got.pop_valid, want.pop_valid);
					check_field("popped_key", got.popped_key, want.popped_key);
					check_field("key_pushed", got.key_pushed, want.key_pushed);
					check_field("key_dropped", got.key_dropped, want.key_dropped);
					check_field("unknown_code", got.unknown_code, want.unknown_code);
					check_field("caps_on", got.caps_on, want.caps_on);
					check_field("buffered_count", got.buffered_count, want.buffered_count);
				end
			end
			if (cfg_valid && cfg_ready && cfg_index < CFG_NUM) begin
				key_codes[cfg_index] = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				decode_item(s_tdata, pred);
				decode_results_q.push_back(pred);
			end
			results_outstanding = decode_results_q.size();
		end
	end

endmodule

/* tb/sv/tb_keyboard_scancode_decoder_core.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for keyboard_scancode_decoder_core: loads the keymaps, runs directed
// and random scancode, pop and keymap traffic under several register settings and idling modes.
// Depends on ksd_pkg, keyboard_scancode_decoder_core and keyboard_scancode_decoder_checker.
module tb_keyboard_scancode_decoder_core;
	import ksd_pkg::*;

	localparam int         LIMIT_CYCLES = 200000;
	localparam int         HOLD_OFF_LEN = 300;
	localparam int         RANDOM_ITEMS = 12;
	localparam logic [6:0] SC_NONE      = 7'h00;
	localparam logic [6:0] SC_Q         = 7'h10;
	localparam logic [6:0] SC_CTRL      = 7'h1D;
	localparam logic [6:0] SC_A         = 7'h1E;
	localparam logic [6:0] SC_LSHIFT    = 7'h2A;
	localparam logic [6:0] SC_RSHIFT    = 7'h36;
	localparam logic [6:0] SC_ALT       = 7'h38;
	localparam logic [6:0] SC_CAPS      = 7'h3A;
	localparam logic [6:0] SC_TOP       = 7'h7F;
	localparam logic [7:0] BRK          = 8'h80;

	typedef logic [KEY_W-1:0] code_set_t [CFG_NUM];

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [39:0]          s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_LSHIFT;
	logic [KEY_W-1:0]     cfg_data = '0;
	int                   fail_count;
	int                   results_outstanding;
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;
	int                   hold_off_target = 0;
	int                   held_cycles = 0;
	int                   cycle_count = 0;

	keyboard_scancode_decoder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	keyboard_scancode_decoder_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.s_tvalid            (s_tvalid),
		.s_tready            (s_tready),
		.s_tdata             (s_tdata),
		.m_tvalid            (m_tvalid),
		.m_tready            (m_tready),
		.m_tdata             (m_tdata),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.fail_count          (fail_count),
		.results_outstanding (results_outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (held_cycles < hold_off_target) begin
			m_tready <= 1'b0;
			held_cycles++;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return CFG_RESET_BASE + KEY_W'($urandom_range(6));
			4, 5, 6: return KEY_W'($urandom_range(16'h7B, 16'h40));
			7: return KEY_W'($urandom);
			default: return KEY_W'($urandom_range(16'h7E, 16'h20));
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] keymap_seed(input tbl_t t, input logic [6:0] i);
		if ((t == TBL_PLAIN || t == TBL_SHIFT) && i == SC_LSHIFT) begin
			return CFG_RESET_BASE + KEY_W'(CFG_LSHIFT);
		end
		if ((t == TBL_PLAIN || t == TBL_SHIFT) && i == SC_RSHIFT) begin
			return CFG_RESET_BASE + KEY_W'(CFG_RSHIFT);
		end
		if (t == TBL_PLAIN) begin
			case (i)
				SC_CTRL: return CFG_RESET_BASE + KEY_W'(CFG_LCONTROL);
				SC_ALT:  return CFG_RESET_BASE + KEY_W'(CFG_LALT);
				SC_CAPS: return CFG_RESET_BASE + KEY_W'(CFG_CAPSLOCK);
				SC_A:    return 16'h0061;
				SC_Q:    return 16'h0051;
				SC_NONE: return 16'h0000;
				SC_TOP:  return 16'hFFFF;
				default: return pick_key();
			endcase
		end
		if (t == TBL_ESC && i == SC_CTRL) begin
			return CFG_RESET_BASE + KEY_W'(CFG_RCONTROL);
		end
		if ((t == TBL_ESC || t == TBL_ALTGR) && i == SC_ALT) begin
			return CFG_RESET_BASE + KEY_W'(CFG_RALT);
		end
		if (t == TBL_SHIFT && i == SC_A) begin
			return 16'h0041;
		end
		if (t == TBL_ALTGR && i == SC_A) begin
			return 16'h20AC;
		end
		return pick_key();
	endfunction

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic scan(input logic [7:0] b);
		in_item_t it;
		it = '0;
		it.op = OP_SCAN;
		it.scan_byte = b;
		it.table_select = 2'($urandom);
		it.table_index = 7'($urandom);
		it.table_value = KEY_W'($urandom);
		send_item(it);
	endtask

	task automatic pop_key();
		in_item_t it;
		it = '0;
		it.op = OP_POP;
		send_item(it);
	endtask

	task automatic write_keymap(input tbl_t t, input logic [6:0] i, input logic [KEY_W-1:0] v);
		in_item_t it;
		it = '0;
		it.op = OP_KEYMAP;
		it.table_select = t;
		it.table_index = i;
		it.table_value = v;
		send_item(it);
	endtask

	task automatic send_reserved();
		in_item_t it;
		it = '0;
		it.op = OP_RSVD;
		it.scan_byte = 8'($urandom);
		it.table_select = 2'($urandom);
		it.table_index = 7'($urandom);
		it.table_value = KEY_W'($urandom);
		send_item(it);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (results_outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [KEY_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_code_set(input code_set_t cs, input logic hit_unused);
		for (int i = 0; i < CFG_NUM; i++) begin
			write_reg(cfg_idx_t'(i), cs[i]);
		end
		if (hit_unused) begin
			write_reg(CFG_NONE, 16'h0100);
		end
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_random(input int n);
		int          sent;
		int          pick;
		logic [6:0]  code;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				// fill the ring with presses
				repeat (18) scan({1'b0, 7'($urandom)});
				sent += 18;
			end else if (pick < 16) begin
				scan(ESCAPE_BYTE);
				scan(8'($urandom));
				sent += 2;
			end else if (pick < 40) begin
				code = 7'($urandom);
				scan({1'b0, code});
				scan({1'b1, code});
				sent += 2;
			end else if (pick < 65) begin
				pop_key();
				sent++;
			end else if (pick < 75) begin
				write_keymap(tbl_t'($urandom_range(3)), 7'($urandom), pick_key());
				sent++;
			end else if (pick < 80) begin
				send_reserved();
				sent++;
			end else begin
				scan(8'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int t = 0; t < KM_TBLS; t++) begin
			for (int i = 0; i < KM_ROWS; i++) begin
				write_keymap(tbl_t'(t), 7'(i), keymap_seed(tbl_t'(t), 7'(i)));
			end
		end

		pop_key();
		send_reserved();
		scan({1'b0, SC_A});
		scan(BRK | {1'b0, SC_A});
		scan({1'b0, SC_CAPS});
		scan({1'b0, SC_A});
		scan(BRK | {1'b0, SC_CAPS});
		scan({1'b0, SC_RSHIFT});
		scan({1'b0, SC_A});
		scan(BRK | {1'b0, SC_LSHIFT});
		scan(ESCAPE_BYTE);
		scan(ESCAPE_BYTE);
		scan({1'b0, SC_ALT});
		scan({1'b0, SC_A});
		scan(ESCAPE_BYTE);
		scan(BRK | {1'b0, SC_ALT});
		scan({1'b0, SC_NONE});
		scan(BRK | {1'b0, SC_NONE});
		scan({1'b0, SC_TOP});
		scan(8'hFF);
		scan({1'b0, SC_CTRL});
		scan(BRK | {1'b0, SC_CTRL});
		scan({1'b0, SC_ALT});
		scan(BRK | {1'b0, SC_ALT});
		pop_key();
		pop_key();
		wait_drained();

		// overfill the ring while the result side holds off
		hold_off_target = held_cycles + HOLD_OFF_LEN;
		repeat (20) scan({1'b0, SC_Q});
		repeat (16) pop_key();
		run_random(RANDOM_ITEMS);
		wait_drained();

		apply_code_set('{16'h0000, 16'hFFFF, 16'h0061, 16'h0106, 16'h0105, 16'h0104,
			16'h0103}, 1'b0);
		send_idle_pct = 64;
		run_random(RANDOM_ITEMS);
		wait_drained();

		apply_code_set('{16'h0101, 16'h0104, 16'h0101, 16'h0104, 16'h0105, 16'h0105,
			16'h0106}, 1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 64;
		hold_off_target = held_cycles + HOLD_OFF_LEN;
		run_random(RANDOM_ITEMS);
		wait_drained();

		apply_code_set('{16'h0100, 16'h0101, 16'h0102, 16'h0103, 16'h0104, 16'h0105,
			16'h0106}, 1'b1);
		send_idle_pct = 10;
		recv_stall_pct = 10;
		run_random(RANDOM_ITEMS);
		wait_drained();

		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ksd_pkg.sv
rtl/core/ksd_keymap.sv
rtl/core/keyboard_scancode_decoder_core.sv
tb/sv/keyboard_scancode_decoder_checker.sv
tb/sv/tb_keyboard_scancode_decoder_core.sv
